### design/tlvp_pkg.sv
package tlvp_pkg;

    // Container depth limit and the widest string length that is accepted.
    localparam int MAX_NESTING        = 16;
    localparam int STRING_LENGTH_BITS = 32;
    localparam int DEPTH_W            = $clog2(MAX_NESTING + 1);

    // Control byte fields and special element types.
    localparam logic [4:0] TYPE_INT_LAST   = 5'h07;
    localparam logic [4:0] TYPE_BOOL_LAST  = 5'h09;
    localparam logic [4:0] TYPE_STR_FIRST  = 5'h10;
    localparam logic [4:0] TYPE_STR_LAST   = 5'h13;
    localparam logic [4:0] TYPE_CONT_FIRST = 5'h15;
    localparam logic [4:0] TYPE_CONT_LAST  = 5'h17;
    localparam logic [4:0] TYPE_END        = 5'h18;
    localparam logic [2:0] TAG_ANON        = 3'd0;
    localparam logic [2:0] TAG_CONTEXT     = 3'd1;

    // Byte roles reported with each result item.
    localparam logic [2:0] ROLE_CONTROL = 3'd0;
    localparam logic [2:0] ROLE_TAG     = 3'd1;
    localparam logic [2:0] ROLE_INT     = 3'd2;
    localparam logic [2:0] ROLE_STRLEN  = 3'd3;
    localparam logic [2:0] ROLE_STRBYTE = 3'd4;
    localparam logic [2:0] ROLE_END     = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
    localparam logic [2:0] ST_TOO_DEEP    = 3'd2;
    localparam logic [2:0] ST_TOO_LONG    = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;
    localparam logic [2:0] ST_STOPPED     = 3'd5;

    typedef enum logic [2:0] {
        PH_CONTROL,
        PH_TAG,
        PH_INT,
        PH_STRLEN,
        PH_STRBYTE
    } tlvp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } tlvp_in_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [4:0]  element_type;
        logic [2:0]  tag_form;
        logic [7:0]  context_tag;
        logic [63:0] field_value;
        logic        element_done;
        logic [4:0]  nesting_depth;
        logic [2:0]  status;
        logic        last_out;
    } tlvp_out_t;

    // Parser state carried from one item to the next.
    typedef struct packed {
        tlvp_phase_t                   phase;
        logic [4:0]                    cur_type;
        logic [2:0]                    cur_tag_form;
        logic [7:0]                    saved_tag;
        logic [3:0]                    field_left;
        logic [63:0]                   acc;
        logic [STRING_LENGTH_BITS-1:0] str_left;
        logic [DEPTH_W-1:0]            depth;
        logic                          halted;
    } tlvp_state_t;

    localparam tlvp_state_t STATE_RESET = '{
        phase:        PH_CONTROL,
        cur_type:     5'd0,
        cur_tag_form: 3'd0,
        saved_tag:    8'd0,
        field_left:   4'd0,
        acc:          64'd0,
        str_left:     '0,
        depth:        '0,
        halted:       1'b0
    };

    // Octet count selected by the low two bits of an integer or string type.
    function automatic logic [3:0] octet_size(input logic [1:0] code);
        logic [3:0] size;
        case (code)
            2'd0:    size = 4'd1;
            2'd1:    size = 4'd2;
            2'd2:    size = 4'd4;
            default: size = 4'd8;
        endcase
        return size;
    endfunction

endpackage

### design/tlvp_step.sv
module tlvp_step (
    input  tlvp_pkg::tlvp_state_t state,
    input  tlvp_pkg::tlvp_in_t    item,
    output tlvp_pkg::tlvp_state_t state_next,
    output tlvp_pkg::tlvp_out_t   result
);
    import tlvp_pkg::*;

    logic [7:0]  b;
    logic [2:0]  tf;
    logic [4:0]  et;
    logic [4:0]  body_type;
    logic        do_body;
    logic [2:0]  lane;
    logic [63:0] acc_new;
    logic [3:0]  left_new;
    logic        over;
    logic [STRING_LENGTH_BITS-1:0] str_new;

    assign b  = item.data_byte;
    assign tf = b[7:5];
    assign et = b[4:0];

    // Little-endian byte placement for integer values and string lengths.
    assign lane     = 3'(octet_size(state.cur_type[1:0]) - state.field_left);
    assign acc_new  = state.acc | (64'(b) << {lane, 3'b000});
    assign left_new = state.field_left - 4'd1;
    assign over     = (STRING_LENGTH_BITS >= 64) ? 1'b0
                    : (|(acc_new >> STRING_LENGTH_BITS));
    assign str_new  = state.str_left - 1'b1;

    // One parsing step for the current byte.
    always_comb
    begin
        state_next = state;
        result     = '0;
        result.byte_role = ROLE_IGNORED;
        result.status    = ST_OK;
        do_body    = 1'b0;
        body_type  = state.cur_type;

        if (state.halted)
        begin
            result.status = ST_STOPPED;
        end
        else
        begin
            case (state.phase)
                PH_CONTROL:
                begin
                    result.byte_role    = ROLE_CONTROL;
                    result.element_type = et;
                    result.tag_form     = tf;
                    if (tf == TAG_ANON && et == TYPE_END)
                    begin
                        result.byte_role    = ROLE_END;
                        result.element_done = 1'b1;
                        if (state.depth == '0)
                            state_next.halted = 1'b1;
                        else
                            state_next.depth = state.depth - 1'b1;
                    end
                    else if (tf > TAG_CONTEXT || !(et <= TYPE_BOOL_LAST
                             || (et >= TYPE_STR_FIRST && et <= TYPE_CONT_LAST)))
                    begin
                        result.status     = ST_UNSUPPORTED;
                        state_next.halted = 1'b1;
                    end
                    else if (et >= TYPE_CONT_FIRST && et <= TYPE_CONT_LAST
                             && 32'(state.depth) >= 32'(MAX_NESTING))
                    begin
                        result.status     = ST_TOO_DEEP;
                        state_next.halted = 1'b1;
                    end
                    else
                    begin
                        state_next.cur_type     = et;
                        state_next.cur_tag_form = tf;
                        state_next.saved_tag    = 8'd0;
                        body_type               = et;
                        if (tf == TAG_CONTEXT)
                            state_next.phase = PH_TAG;
                        else
                            do_body = 1'b1;
                    end
                end
                PH_TAG:
                begin
                    result.byte_role    = ROLE_TAG;
                    result.element_type = state.cur_type;
                    result.tag_form     = state.cur_tag_form;
                    result.context_tag  = b;
                    state_next.saved_tag = b;
                    do_body = 1'b1;
                end
                PH_INT, PH_STRLEN:
                begin
                    result.byte_role    = (state.phase == PH_INT) ? ROLE_INT : ROLE_STRLEN;
                    result.element_type = state.cur_type;
                    result.tag_form     = state.cur_tag_form;
                    result.context_tag  = state.saved_tag;
                    result.field_value  = acc_new;
                    state_next.acc        = acc_new;
                    state_next.field_left = left_new;
                    if (left_new == 4'd0)
                    begin
                        state_next.phase = PH_CONTROL;
                        if (state.phase == PH_INT)
                            result.element_done = 1'b1;
                        else if (over)
                        begin
                            result.status     = ST_TOO_LONG;
                            state_next.halted = 1'b1;
                        end
                        else if (acc_new == 64'd0)
                            result.element_done = 1'b1;
                        else
                        begin
                            state_next.str_left = acc_new[STRING_LENGTH_BITS-1:0];
                            state_next.phase    = PH_STRBYTE;
                        end
                    end
                end
                PH_STRBYTE:
                begin
                    result.byte_role    = ROLE_STRBYTE;
                    result.element_type = state.cur_type;
                    result.tag_form     = state.cur_tag_form;
                    result.context_tag  = state.saved_tag;
                    result.field_value  = state.acc;
                    state_next.str_left = str_new;
                    if (str_new == '0)
                    begin
                        result.element_done = 1'b1;
                        state_next.phase    = PH_CONTROL;
                    end
                end
                default:
                begin
                    state_next.phase = PH_CONTROL;
                end
            endcase

            // Header finished: set up the value, open a container, or finish.
            if (do_body)
            begin
                if (body_type <= TYPE_INT_LAST)
                begin
                    state_next.phase      = PH_INT;
                    state_next.field_left = octet_size(body_type[1:0]);
                    state_next.acc        = 64'd0;
                end
                else if (body_type >= TYPE_STR_FIRST && body_type <= TYPE_STR_LAST)
                begin
                    state_next.phase      = PH_STRLEN;
                    state_next.field_left = octet_size(body_type[1:0]);
                    state_next.acc        = 64'd0;
                end
                else if (body_type >= TYPE_CONT_FIRST && body_type <= TYPE_CONT_LAST)
                begin
                    state_next.depth = state.depth + 1'b1;
                    state_next.phase = PH_CONTROL;
                end
                else
                begin
                    state_next.phase    = PH_CONTROL;
                    result.element_done = 1'b1;
                end
            end
        end

        // A buffer that ends partway through an element's header or value is truncated.
        if (item.buffer_end && !state_next.halted && result.status == ST_OK
            && state_next.phase != PH_CONTROL)
            result.status = ST_TRUNCATED;

        result.nesting_depth = 5'(state_next.depth);
        result.last_out      = item.buffer_end;

        // The next byte after the buffer's last one starts a fresh buffer.
        if (item.buffer_end)
            state_next = STATE_RESET;
    end

endmodule

### design/tlv_element_stream_parser.sv
// Channel | Direction | Payload    | Handshake
// in      | input     | tlvp_in_t  | in_valid / in_ready
// out     | output    | tlvp_out_t | out_valid / out_ready
//
// One result item per input byte, one byte per cycle sustained while out_ready holds.
// A byte is held in the input register and its result is then registered in the
// result register, from which it is offered on the output channel.
// The parser state advances only when a byte moves from the input register into
// the result register; a stalled output holds both stages without loss.
// Reset returns the parser to expecting a control byte at depth zero.
module tlv_element_stream_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tlvp_pkg::tlvp_in_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tlvp_pkg::tlvp_out_t out_item
);
    import tlvp_pkg::*;

    logic        in_valid_reg;
    tlvp_in_t    in_item_reg;
    logic        out_valid_reg;
    tlvp_out_t   out_item_reg;
    tlvp_state_t state_reg;
    tlvp_state_t state_next;
    tlvp_out_t   result;
    logic        advance;

    // The result register frees up when empty or when its item is taken.
    assign advance  = out_ready || !out_valid_reg;
    assign in_ready = !in_valid_reg || advance;

    tlvp_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
